[rtl/core/aptt_pkg.sv]
// Shared types and constants of the aperture page translation table.
package aptt_pkg;

  localparam int unsigned CNT_W   = 17;  // holds any page count up to 65537
  localparam int unsigned PG_SH   = 12;
  localparam int unsigned PPN_W   = 64 - PG_SH;
  localparam int unsigned ENTRY_W = PPN_W + 2;

  typedef enum logic [1:0] {
    OP_MAP     = 2'd0,
    OP_UNMAP   = 2'd1,
    OP_RESOLVE = 2'd2,
    OP_BAD     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_RANGE      = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_NOT_MAPPED = 3'd4,
    ST_DUMMY      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    EN_EMPTY  = 2'd0,
    EN_MAPPED = 2'd1,
    EN_DUMMY  = 2'd2
  } entry_e;

  typedef enum logic [1:0] {
    RERR_NONE      = 2'd0,
    RERR_ZERO      = 2'd1,
    RERR_MISALIGNED = 2'd2
  } rerr_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_COMMIT,
    BK_FILL,
    BK_LOOKUP
  } bk_state_e;

  typedef struct packed {
    op_e         kind;
    logic [15:0] first_page;
    logic [15:0] run_count;
    logic [63:0] phys;
    logic [63:0] offset;
    logic        last;
    logic        phys_zero;
    logic        phys_misal;
  } cmd_t;

endpackage

[rtl/core/aptt_ram.sv]
// Generic single write port, single read port RAM with registered read.
module aptt_ram #(
  parameter int unsigned W  = 8,
  parameter int unsigned D  = 16,
  parameter int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/core/aptt_front.sv]
// Front end: accepts words, classifies them and queues commands for the back end.
module aptt_front import aptt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   opcode_i,
  input  logic [15:0]  first_page_i,
  input  logic [15:0]  page_run_count_i,
  input  logic [63:0]  phys_value_i,
  input  logic [63:0]  byte_offset_i,
  input  logic         last_in_run_i,
  output logic         cmd_valid_o,
  output cmd_t         cmd_o,
  input  logic         cmd_pop_i
);

  cmd_t       q_mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in            = '0;
    cmd_in.kind       = op_e'(opcode_i);
    cmd_in.first_page = first_page_i;
    cmd_in.run_count  = page_run_count_i;
    cmd_in.phys       = phys_value_i;
    cmd_in.offset     = byte_offset_i;
    cmd_in.last       = last_in_run_i;
    cmd_in.phys_zero  = (phys_value_i == 64'd0);
    cmd_in.phys_misal = (phys_value_i[PG_SH-1:0] != '0);
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule

[rtl/core/aptt_back.sv]
// Back end: staging store, translation table, range walks and result register.
module aptt_back import aptt_pkg::*; #(
  parameter int unsigned MAX_PAGES = 4096,
  parameter int unsigned AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_data_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [63:0] addr_o
);

  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_PAGES);

  bk_state_e        state_q, state_d;
  logic [12:0]      pages_q;
  logic [CNT_W-1:0] run_pos_q, run_pos_d;
  logic [15:0]      rfp_q, rfp_d;
  rerr_e            rerr_q, rerr_d;
  logic [CNT_W-1:0] idx_q, idx_d, cnt_q, cnt_d, base_q, base_d;
  logic [PPN_W-1:0] dummy_q, dummy_d;
  logic [PG_SH-1:0] off_lo_q, off_lo_d;
  logic             wv_q, wv_d;
  logic [AW-1:0]    wa_q, wa_d;
  logic             ov_q, ov_d;
  logic [2:0]       st_q, st_d;
  logic [63:0]      ad_q, ad_d;

  logic [CNT_W-1:0] n_act, cnt_new, first_ext, count_ext;
  logic             fits_map, fits_unmap, rd_more;
  logic             stg_we, e_we, e_re;
  logic [AW-1:0]    e_waddr, e_raddr;
  logic [ENTRY_W-1:0] e_wdata, e_rdata;
  logic [PPN_W-1:0] stg_rdata, res_page;
  rerr_e            rerr_new;
  logic [15:0]      rfp_new;

  function automatic logic fits(input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] f,
                                input logic [CNT_W-1:0] c);
    fits = (n != '0) && (c != '0) && (f < n) && (c <= n - f);
  endfunction

  assign n_act = ({4'd0, pages_q} > MAXC) ? MAXC : CNT_W'(pages_q);

  // Map item bookkeeping, used when a map command pops
  always_comb begin
    rfp_new  = (run_pos_q == '0) ? cmd_i.first_page : rfp_q;
    rerr_new = (run_pos_q == '0) ? RERR_NONE : rerr_q;
    if (rerr_new == RERR_NONE) begin
      if (cmd_i.phys_zero) rerr_new = RERR_ZERO;
      else if (cmd_i.phys_misal) rerr_new = RERR_MISALIGNED;
    end
    cnt_new = (run_pos_q < MAXC + 1'b1) ? run_pos_q + 1'b1 : run_pos_q;
  end

  assign first_ext  = CNT_W'(cmd_i.first_page);
  assign count_ext  = CNT_W'(cmd_i.run_count);
  assign fits_map   = fits(n_act, CNT_W'(rfp_new), cnt_new);
  assign fits_unmap = fits(n_act, first_ext, count_ext);
  assign rd_more    = (idx_q < cnt_q);
  assign res_page   = e_rdata[PPN_W-1:0];

  assign cmd_pop_o = (state_q == BK_IDLE) && cmd_valid_i && !ov_q;
  assign stg_we    = cmd_pop_o && (cmd_i.kind == OP_MAP) && (run_pos_q < MAXC);
  assign e_re      = cmd_pop_o && (cmd_i.kind == OP_RESOLVE);
  assign e_raddr   = cmd_i.offset[PG_SH +: AW];

  always_comb begin
    state_d   = state_q;
    run_pos_d = run_pos_q;
    rfp_d     = rfp_q;
    rerr_d    = rerr_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    base_d    = base_q;
    dummy_d   = dummy_q;
    off_lo_d  = off_lo_q;
    wv_d      = 1'b0;
    wa_d      = wa_q;
    ov_d      = ov_q && !out_ready_i;
    st_d      = st_q;
    ad_d      = ad_q;
    e_we      = 1'b0;
    e_waddr   = idx_q[AW-1:0];
    e_wdata   = '0;
    case (state_q)
      BK_CLEAR: begin
        e_we  = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == MAXC - 1'b1) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (cmd_pop_o) begin
          ad_d = '0;
          case (cmd_i.kind)
            OP_MAP: begin
              rfp_d     = rfp_new;
              rerr_d    = rerr_new;
              run_pos_d = cnt_new;
              if (cmd_i.last) begin
                run_pos_d = '0;
                ov_d      = 1'b1;
                if (!fits_map) st_d = ST_RANGE;
                else if (rerr_new == RERR_ZERO) st_d = ST_INVALID;
                else if (rerr_new == RERR_MISALIGNED) st_d = ST_MISALIGNED;
                else begin
                  ov_d    = 1'b0;
                  st_d    = ST_OK;
                  base_d  = CNT_W'(rfp_new);
                  cnt_d   = cnt_new;
                  idx_d   = '0;
                  state_d = BK_COMMIT;
                end
              end
            end
            OP_UNMAP: begin
              ov_d = 1'b1;
              if (count_ext == '0 || cmd_i.phys_zero) st_d = ST_INVALID;
              else if (cmd_i.phys_misal) st_d = ST_MISALIGNED;
              else if (!fits_unmap) st_d = ST_RANGE;
              else begin
                ov_d    = 1'b0;
                st_d    = ST_OK;
                base_d  = first_ext;
                cnt_d   = count_ext;
                idx_d   = '0;
                dummy_d = cmd_i.phys[63:PG_SH];
                state_d = BK_FILL;
              end
            end
            OP_RESOLVE: begin
              off_lo_d = cmd_i.offset[PG_SH-1:0];
              if (n_act == '0) begin
                ov_d = 1'b1;
                st_d = ST_INVALID;
              end else if (cmd_i.offset[63:PG_SH] >= PPN_W'(n_act)) begin
                ov_d = 1'b1;
                st_d = ST_RANGE;
              end else begin
                state_d = BK_LOOKUP;
              end
            end
            default: begin
              ov_d = 1'b1;
              st_d = ST_INVALID;
            end
          endcase
        end
      end
      BK_COMMIT: begin
        // staging read is registered; its data is written to the table in the next cycle
        if (rd_more) begin
          idx_d = idx_q + 1'b1;
          wv_d  = 1'b1;
          wa_d  = AW'(base_q + idx_q);
        end
        e_we    = wv_q;
        e_waddr = wa_q;
        e_wdata = {EN_MAPPED, stg_rdata};
        if (!rd_more && !wv_q) begin
          ov_d    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      BK_FILL: begin
        e_waddr = AW'(base_q + idx_q);
        e_wdata = {EN_DUMMY, dummy_q};
        if (rd_more) begin
          e_we  = 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          ov_d    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      BK_LOOKUP: begin
        ov_d    = 1'b1;
        state_d = BK_IDLE;
        if (entry_e'(e_rdata[ENTRY_W-1 -: 2]) == EN_EMPTY || res_page == '0) begin
          st_d = ST_NOT_MAPPED;
        end else begin
          st_d = (entry_e'(e_rdata[ENTRY_W-1 -: 2]) == EN_DUMMY) ? ST_DUMMY : ST_OK;
          ad_d = {res_page, off_lo_q};
        end
      end
      default: state_d = BK_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d   = BK_CLEAR;
      idx_d     = '0;
      run_pos_d = '0;
      rerr_d    = RERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      pages_q   <= 13'd4096;
      run_pos_q <= '0;
      rfp_q     <= '0;
      rerr_q    <= RERR_NONE;
      idx_q     <= '0;
      wv_q      <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      run_pos_q <= run_pos_d;
      rfp_q     <= rfp_d;
      rerr_q    <= rerr_d;
      idx_q     <= idx_d;
      wv_q      <= wv_d;
      ov_q      <= ov_d;
      if (cfg_we_i) pages_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    base_q   <= base_d;
    dummy_q  <= dummy_d;
    off_lo_q <= off_lo_d;
    wa_q     <= wa_d;
    st_q     <= st_d;
    ad_q     <= ad_d;
  end

  aptt_ram #(.W(PPN_W), .D(MAX_PAGES), .AW(AW)) u_staging (
    .clk_i   (clk_i),
    .we_i    (stg_we),
    .waddr_i (run_pos_q[AW-1:0]),
    .wdata_i (cmd_i.phys[63:PG_SH]),
    .re_i    (state_q == BK_COMMIT),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (stg_rdata)
  );

  aptt_ram #(.W(ENTRY_W), .D(MAX_PAGES), .AW(AW)) u_table (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign addr_o      = ad_q;

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == BK_IDLE) && !ov_q)
    else $error("command popped while back end busy");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CLEAR) |=> !$rose(ov_q))
    else $error("result raised during clearing pass");

  a_err_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && st_q != ST_OK && st_q != ST_DUMMY) |-> (ad_q == '0))
    else $error("nonzero address on error result");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q && $stable(st_q) && $stable(ad_q))
    else $error("pending result changed");

endmodule

[rtl/core/aperture_page_translation_table_top.sv]
// Top level of the aperture page translation table.
// Translates an aperture of 4 KiB pages to physical addresses. Map runs are
// staged item by item and committed on the last item only if the range fits
// and every page is nonzero and aligned; unmap fills a range with a dummy
// page; resolve returns status and physical address (zero on error). A
// resolve reads the table through its registered read port; commits and
// unmap fills write one table entry per cycle through the single table
// write port. The back end handles one word at a time and waits while a
// result is not yet taken; a two-entry command queue in the front keeps the
// input side accepting meanwhile until it is full. After reset and after
// every write of the pages-in-use register a clearing pass empties the
// table; no command is executed during it (input words still queue).
module aperture_page_translation_table_top import aptt_pkg::*; #(
  parameter int unsigned MAX_PAGES = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // fields low to high: opcode[1:0], first_page[17:2], page_run_count[33:18],
  // phys_value[97:34], byte_offset[161:98], zero fill
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [167:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,   // last_in_run
  // fields low to high: status[2:0], phys_address[66:3], zero fill
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [71:0]  m_axis_tdata_o,
  // pages_in_use register write
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [12:0]  cfg_data_i
);

  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;
  logic [2:0] status;
  logic [63:0] addr;

  assign cfg_ready_o = 1'b1;

  aptt_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .opcode_i         (s_axis_tdata_i[1:0]),
    .first_page_i     (s_axis_tdata_i[17:2]),
    .page_run_count_i (s_axis_tdata_i[33:18]),
    .phys_value_i     (s_axis_tdata_i[97:34]),
    .byte_offset_i    (s_axis_tdata_i[161:98]),
    .last_in_run_i    (s_axis_tlast_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  aptt_back #(.MAX_PAGES(MAX_PAGES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_o    (status),
    .addr_o      (addr)
  );

  assign m_axis_tdata_o = {5'd0, addr, status};

endmodule
